### rtl/core/crcm_pkg.sv
// ----------------------------------------------------------------------------
// crcm_pkg
// Types, constants and bit-level helpers for the CRC-16 (0x1021) byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package crcm_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam int CFG_DATA_W = 9;

    typedef enum logic [0:0] {
        REG_PRESET_BYTE    = 1'b0,
        REG_REFLECT_ENABLE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first;
        logic        last;
        logic [15:0] seed;
    } t_in_item;

    typedef struct packed {
        logic [15:0] crc_value;
        logic        done_res;
    } t_out_item;

    typedef struct packed {
        logic signed [8:0] preset_byte;
        logic              reflect_enable;
    } t_cfg;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] v);
        return {rev8(v[7:0]), rev8(v[15:8])};
    endfunction

    // eight MSB-first shift steps of the remainder with the byte folded in
    function automatic logic [15:0] crc_byte(input logic [15:0] rem, input logic [7:0] b);
        logic [15:0] a;
        a = rem ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((a & CRC_TOP) != 16'h0000) begin
                a = {a[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                a = {a[14:0], 1'b0};
            end
        end
        return a;
    endfunction

endpackage

`default_nettype wire

### rtl/core/crcm_cfg.sv
// ----------------------------------------------------------------------------
// crcm_cfg
// Configuration register file: preset byte and reflect mode.
// ----------------------------------------------------------------------------
`default_nettype none

module crcm_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire crcm_pkg::t_cfg_idx                  i_cfg_idx,
    input  wire logic [crcm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output crcm_pkg::t_cfg                           o_cfg
);
    import crcm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preset_byte    <= '0;
            r_cfg.reflect_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PRESET_BYTE:    r_cfg.preset_byte    <= signed'(i_cfg_data);
                REG_REFLECT_ENABLE: r_cfg.reflect_enable <= i_cfg_data[0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/core/crcm_calc.sv
// ----------------------------------------------------------------------------
// crcm_calc
// Preset selection, reflection and unrolled 8-bit CRC update.
// ----------------------------------------------------------------------------
`default_nettype none

module crcm_calc (
    input  wire crcm_pkg::t_cfg      i_cfg,
    input  wire crcm_pkg::t_in_item  i_item,
    input  wire logic [15:0]         i_remainder,
    output logic [15:0]              o_next_rem,
    output logic [15:0]              o_crc_value
);
    import crcm_pkg::*;

    logic [15:0] start_rem;
    logic [7:0]  msg_byte;

    always_comb begin
        if (i_item.first) begin
            if (!i_cfg.preset_byte[8]) begin
                start_rem = {i_cfg.preset_byte[7:0], i_cfg.preset_byte[7:0]};
            end else if (i_cfg.reflect_enable) begin
                start_rem = rev16(i_item.seed);
            end else begin
                start_rem = i_item.seed;
            end
        end else begin
            start_rem = i_remainder;
        end
        msg_byte    = i_cfg.reflect_enable ? rev8(i_item.data_byte) : i_item.data_byte;
        o_next_rem  = crc_byte(start_rem, msg_byte);
        o_crc_value = i_cfg.reflect_enable ? rev16(o_next_rem) : o_next_rem;
    end

endmodule

`default_nettype wire

### rtl/core/crc16_ccitt_modes.sv
// An accepted word waits in the input register until the update stage registers its result.
// Throughput: one word per cycle while results are taken; the CRC update is a single registered pass.
// Input register and result register; input ready follows result ready when both are full.
// Reset (sync, active low) clears valids, remainder and config registers.
// ----------------------------------------------------------------------------
// crc16_ccitt_modes
// Byte-serial CRC-16 (0x1021, MSB first) with preset, seed and reflect modes.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_ccitt_modes (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire crcm_pkg::t_cfg_idx                  i_cfg_idx,
    input  wire logic [crcm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire crcm_pkg::t_in_item                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output crcm_pkg::t_out_item                      o_out_data
);
    import crcm_pkg::*;

    t_cfg        cfg;
    t_in_item    r_in;
    logic        r_in_valid;
    t_out_item   r_out;
    logic        r_out_valid;
    logic [15:0] r_remainder;
    logic [15:0] n_remainder;
    logic [15:0] crc_value;
    logic        out_load;
    logic        advance;

    crcm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    crcm_calc u_calc (
        .i_cfg       (cfg),
        .i_item      (r_in),
        .i_remainder (r_remainder),
        .o_next_rem  (n_remainder),
        .o_crc_value (crc_value)
    );

    assign out_load   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_load;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_remainder <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_remainder <= n_remainder;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out.crc_value <= crc_value;
            r_out.done_res  <= r_in.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // held input word stays put until the update stage takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("input register lost or changed a pending word");

    // a word taken by the update stage shows up as a result
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed word did not reach the result register");

    // remainder only moves when a word is processed
    a_rem_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_remainder))
        else $error("remainder changed without a word");

    // a pending result that is not taken keeps the input side from overrunning it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !advance)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
